@@ src/knp2d_pkg.sv @@
// shared constants and controller/datapath interface types for the k-nearest point search
package knp2d_pkg;

    // store geometry
    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // neighbor list and result widths
    localparam int LIST_LEN   = MAX_POINTS - 1;
    localparam int NC_W       = 6;
    localparam int IDX_W      = 6;
    localparam int DIST_W     = 2 * COORD_BITS + 1;
    localparam logic [NC_W-1:0] NC_RESET = NC_W'(3);

    // operation codes of the func field
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              latch_q;
        logic              scan_valid;
        logic              clear_list;
        logic              shift_out;
        logic              err_result;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic busy;
    } dp_status_t;

endpackage

@@ src/knp2d_datapath.sv @@
// point store, distance pipeline and sorted neighbor list
module knp2d_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  knp2d_pkg::dp_cmd_t           cmd,
    input  logic [15:0]                  x_coord,
    input  logic [15:0]                  y_coord,
    output knp2d_pkg::dp_status_t        dp_status,
    output logic [knp2d_pkg::IDX_W-1:0]  neighbor_index,
    output logic [knp2d_pkg::DIST_W-1:0] distance_squared
);
    import knp2d_pkg::*;

    logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [ADDR_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [COORD_BITS-1:0]   dx_reg, dy_reg;
    logic [2*COORD_BITS-1:0] sqx_reg, sqy_reg;
    logic [DIST_W-1:0]       dist_reg;

    logic signed [COORD_BITS:0] diff_x, diff_y;
    logic signed [COORD_BITS:0] mag_x, mag_y;

    logic              lst_valid_reg  [LIST_LEN];
    logic [DIST_W-1:0] lst_dist_reg   [LIST_LEN];
    logic [ADDR_W-1:0] lst_idx_reg    [LIST_LEN];
    logic              lst_valid_next [LIST_LEN];
    logic [DIST_W-1:0] lst_dist_next  [LIST_LEN];
    logic [ADDR_W-1:0] lst_idx_next   [LIST_LEN];
    logic              lt       [LIST_LEN];
    logic              prev_lt  [LIST_LEN];

    // coordinate memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            x_mem[cmd.wr_addr] <= x_coord[COORD_BITS-1:0];
            y_mem[cmd.wr_addr] <= y_coord[COORD_BITS-1:0];
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= x_mem[cmd.rd_addr];
            rd_y_reg <= y_mem[cmd.rd_addr];
        end
    end

    // absolute coordinate differences against the query point
    always_comb
    begin
        diff_x = {rd_x_reg[COORD_BITS-1], rd_x_reg} - {qx_reg[COORD_BITS-1], qx_reg};
        diff_y = {rd_y_reg[COORD_BITS-1], rd_y_reg} - {qy_reg[COORD_BITS-1], qy_reg};
        mag_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
        mag_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
    end

    // distance pipeline payload: query latch, differences, squares, sum
    always_ff @(posedge clk)
    begin
        if (cmd.latch_q)
        begin
            qx_reg <= rd_x_reg;
            qy_reg <= rd_y_reg;
        end
        s1_idx_reg <= cmd.rd_addr;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        s4_idx_reg <= s3_idx_reg;
        dx_reg     <= mag_x[COORD_BITS-1:0];
        dy_reg     <= mag_y[COORD_BITS-1:0];
        sqx_reg    <= dx_reg * dx_reg;
        sqy_reg    <= dy_reg * dy_reg;
        dist_reg   <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    end

    // distance pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.scan_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // sorted list cells: each compares the new distance with its own entry
    always_comb
    begin
        for (int i = 0; i < LIST_LEN; i++)
        begin
            lt[i] = !lst_valid_reg[i] || (dist_reg < lst_dist_reg[i]);
        end
        prev_lt[0] = 1'b0;
        for (int i = 1; i < LIST_LEN; i++)
        begin
            prev_lt[i] = lt[i-1];
        end
        for (int i = 0; i < LIST_LEN; i++)
        begin
            lst_valid_next[i] = lst_valid_reg[i];
            lst_dist_next[i]  = lst_dist_reg[i];
            lst_idx_next[i]   = lst_idx_reg[i];
            if (cmd.clear_list)
            begin
                lst_valid_next[i] = 1'b0;
            end
            else if (cmd.shift_out)
            begin
                if (i == LIST_LEN - 1)
                begin
                    lst_valid_next[i] = 1'b0;
                end
                else
                begin
                    lst_valid_next[i] = lst_valid_reg[i+1];
                    lst_dist_next[i]  = lst_dist_reg[i+1];
                    lst_idx_next[i]   = lst_idx_reg[i+1];
                end
            end
            else if (s4_valid_reg && lt[i])
            begin
                if (!prev_lt[i])
                begin
                    lst_valid_next[i] = 1'b1;
                    lst_dist_next[i]  = dist_reg;
                    lst_idx_next[i]   = s4_idx_reg;
                end
                else
                begin
                    lst_valid_next[i] = lst_valid_reg[i-1];
                    lst_dist_next[i]  = lst_dist_reg[i-1];
                    lst_idx_next[i]   = lst_idx_reg[i-1];
                end
            end
        end
    end

    // list valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_LEN; i++)
            begin
                lst_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < LIST_LEN; i++)
            begin
                lst_valid_reg[i] <= lst_valid_next[i];
            end
        end
    end

    // list payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_LEN; i++)
        begin
            lst_dist_reg[i] <= lst_dist_next[i];
            lst_idx_reg[i]  <= lst_idx_next[i];
        end
    end

    assign dp_status.busy = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg;

    // head of the list is the next result; error results carry zeros
    assign neighbor_index   = cmd.err_result ? '0 : IDX_W'(lst_idx_reg[0]);
    assign distance_squared = cmd.err_result ? '0 : lst_dist_reg[0];

endmodule

@@ src/knp2d_ctrl.sv @@
// controller: store bookkeeping, query sequencing and result handshake
module knp2d_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [knp2d_pkg::IDX_W-1:0] point_index,
    input  logic                        cfg_wr_en,
    input  logic [knp2d_pkg::NC_W-1:0]  cfg_wr_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        status,
    output logic [knp2d_pkg::NC_W-1:0]  rank,
    output logic                        last,
    output knp2d_pkg::dp_cmd_t          cmd,
    input  knp2d_pkg::dp_status_t       dp_status
);
    import knp2d_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READQ,
        ST_LATCHQ,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_ERR
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [NC_W-1:0]   nc_reg, nc_next;
    logic [NC_W-1:0]   total_reg, total_next;
    logic [NC_W-1:0]   rank_reg, rank_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [ADDR_W-1:0] q_reg, q_next;

    logic [CNT_W-1:0]  avail;
    logic              rank_last;
    logic              scan_last;

    assign avail     = count_reg - CNT_W'(1);
    assign rank_last = (rank_reg == total_reg - NC_W'(1));
    assign scan_last = (CNT_W'(scan_reg) == avail);

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        nc_next    = cfg_wr_en ? cfg_wr_data : nc_reg;
        total_next = total_reg;
        rank_next  = rank_reg;
        scan_next  = scan_reg;
        q_next     = q_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        FUNC_ADD:
                        begin
                            if (count_reg < CNT_W'(MAX_POINTS))
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_QUERY:
                        begin
                            q_next    = ADDR_W'(point_index);
                            rank_next = '0;
                            scan_next = '0;
                            if (CNT_W'(point_index) >= count_reg)
                            begin
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                if (CNT_W'(nc_reg) < avail)
                                begin
                                    total_next = nc_reg;
                                end
                                else
                                begin
                                    total_next = NC_W'(avail);
                                end
                                if ((nc_reg != '0) && (avail != '0))
                                begin
                                    state_next = ST_READQ;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READQ:
            begin
                state_next = ST_LATCHQ;
            end
            ST_LATCHQ:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + ADDR_W'(1);
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_status.busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    rank_next = rank_reg + NC_W'(1);
                    if (rank_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            nc_reg    <= NC_RESET;
            total_reg <= '0;
            rank_reg  <= '0;
            scan_reg  <= '0;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            nc_reg    <= nc_next;
            total_reg <= total_next;
            rank_reg  <= rank_next;
            scan_reg  <= scan_next;
            q_reg     <= q_next;
        end
    end

    // datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.wr_addr    = count_reg[ADDR_W-1:0];
        cmd.rd_addr    = (state_reg == ST_SCAN) ? scan_reg : q_reg;
        cmd.wr_en      = (state_reg == ST_IDLE) && in_valid && (func == FUNC_ADD)
                         && (count_reg < CNT_W'(MAX_POINTS));
        cmd.rd_en      = (state_reg == ST_READQ) || (state_reg == ST_SCAN);
        cmd.clear_list = (state_reg == ST_READQ);
        cmd.latch_q    = (state_reg == ST_LATCHQ);
        cmd.scan_valid = (state_reg == ST_SCAN) && (scan_reg != q_reg);
        cmd.shift_out  = (state_reg == ST_EMIT) && out_ready;
        cmd.err_result = (state_reg == ST_ERR);
    end

    // handshake and result control fields
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT) || (state_reg == ST_ERR);
    assign status    = (state_reg == ST_ERR);
    assign rank      = rank_reg;
    assign last      = (state_reg == ST_ERR) || rank_last;

endmodule

@@ src/k_nearest_points_2d.sv @@
// Nearest-neighbor search over a store of up to 64 2D points. A query reads and
// latches the queried point, then streams every stored point through one memory
// read port and a four-stage distance pipeline into a sorted insertion list, one
// point per cycle; once the pipeline drains, results leave nearest first at one
// per cycle while the receiver is ready.
// A query of an unstored index gives one error result. One transaction is
// worked on at a time.
module k_nearest_points_2d (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [15:0]                  x_coord,
    input  logic [15:0]                  y_coord,
    input  logic [5:0]                   point_index,
    input  logic                         cfg_wr_en,
    input  logic [5:0]                   cfg_wr_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         status,
    output logic [5:0]                   rank,
    output logic [5:0]                   neighbor_index,
    output logic [knp2d_pkg::DIST_W-1:0] distance_squared,
    output logic                         last
);
    import knp2d_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t dp_status;

    // sequencing and bookkeeping
    knp2d_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .point_index (point_index),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .rank        (rank),
        .last        (last),
        .cmd         (cmd),
        .dp_status   (dp_status)
    );

    // store, distances and sorted list
    knp2d_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .dp_status        (dp_status),
        .neighbor_index   (neighbor_index),
        .distance_squared (distance_squared)
    );

endmodule

@@ src/knp2d_checker.sv @@
// port-level checks of the k-nearest point search, bound to the top level
module knp2d_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         status,
    input logic [5:0]                   rank,
    input logic [5:0]                   neighbor_index,
    input logic [knp2d_pkg::DIST_W-1:0] distance_squared,
    input logic                         last
);
    // a pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rank)
            && $stable(neighbor_index) && $stable(distance_squared) && $stable(last))
        else $error("result changed while stalled");

    // no new transaction is taken while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while results pending");

    // error result is a single zeroed transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && rank == '0 && neighbor_index == '0
            && distance_squared == '0)
        else $error("malformed error result");

    // results of one query follow back to back with rising rank
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && rank == $past(rank) + 6'd1)
        else $error("rank sequence broken");

    // nearest first
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last && !status |=>
            distance_squared >= $past(distance_squared))
        else $error("distances out of order");

endmodule

bind k_nearest_points_2d knp2d_checker u_knp2d_checker (.*);

@@ verif/k_nearest_points_2d_test.sv @@
// self-checking testbench for k_nearest_points_2d: directed table plus random point sets
module k_nearest_points_2d_test;

    import knp2d_pkg::*;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam logic       ST_OK         = 1'b0;
    localparam logic       ST_BAD_INDEX  = 1'b1;
    localparam int         TOTAL_ITEMS   = 450;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         DIR_ROWS      = 25;

    // one input transaction
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] x;
        logic [15:0] y;
        logic [5:0]  idx;
    } point_op_t;

    // one output transaction
    typedef struct packed {
        logic              status;
        logic [5:0]        rank;
        logic [5:0]        nbr;
        logic [DIST_W-1:0] dsq;
        logic              last;
    } nbr_result_t;

    // directed row: transaction plus an optional hand-written result
    typedef struct packed {
        point_op_t   op;
        logic        typed;
        nbr_result_t want;
    } dir_row_t;

    localparam nbr_result_t NO_RESULT = '0;
    localparam nbr_result_t BAD_IDX   = '{ST_BAD_INDEX, 6'd0, 6'd0, 33'd0, 1'b1};

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [1:0]        func        = FUNC_CLEAR;
    logic [15:0]       x_coord     = '0;
    logic [15:0]       y_coord     = '0;
    logic [5:0]        point_index = '0;
    logic              cfg_wr_en   = 1'b0;
    logic [5:0]        cfg_wr_data = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              status;
    logic [5:0]        rank;
    logic [5:0]        neighbor_index;
    logic [DIST_W-1:0] distance_squared;
    logic              last;

    // predictor state
    logic signed [15:0] pt_x [MAX_POINTS];
    logic signed [15:0] pt_y [MAX_POINTS];
    int unsigned        stored_count = 0;
    logic [5:0]         neighbor_k   = NC_RESET;
    nbr_result_t        pending_neighbors [$];

    int error_count  = 0;
    int items_sent   = 0;
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    // directed stimulus, typed results only where obvious
    dir_row_t dir_table [DIR_ROWS] = '{
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd0},  1'b1, BAD_IDX},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd63}, 1'b1, BAD_IDX},
        '{'{FUNC_ADD,   16'h0000, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h0003, 16'h0004, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd0},  1'b1, '{ST_OK, 6'd0, 6'd1, 33'd25, 1'b1}},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd1},  1'b1, '{ST_OK, 6'd0, 6'd0, 33'd25, 1'b1}},
        '{'{FUNC_CLEAR, 16'h0000, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h8000, 16'h8000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h7fff, 16'h7fff, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd1},  1'b1,
          '{ST_OK, 6'd0, 6'd0, 33'd8589672450, 1'b1}},
        '{'{FUNC_UNUSED, 16'hffff, 16'h5555, 6'd42}, 1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h8000, 16'h7fff, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h7fff, 16'h8000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'hffff, 16'hffff, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h0000, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h0000, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h0001, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'h0000, 16'hffff, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_ADD,   16'hffff, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd4},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd5},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd9},  1'b1, BAD_IDX},
        '{'{FUNC_CLEAR, 16'h0000, 16'h0000, 6'd0},  1'b0, NO_RESULT},
        '{'{FUNC_QUERY, 16'h0000, 16'h0000, 6'd0},  1'b1, BAD_IDX}
    };

    k_nearest_points_2d u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .point_index      (point_index),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .rank             (rank),
        .neighbor_index   (neighbor_index),
        .distance_squared (distance_squared),
        .last             (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #100_000_000;
        $display("** k_nearest_points_2d: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // append one expected result transaction
    function automatic void expect_result(input nbr_result_t res);
        pending_neighbors.insert(pending_neighbors.size(), res);
    endfunction

    // gap length: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // coordinate styles: tight cluster for ties, full range, extremes, mid range
    function automatic logic [15:0] rand_coord(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 6)) - 16'd3;
            1: return 16'($urandom);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            default: return 16'($urandom_range(0, 600)) - 16'd300;
        endcase
    endfunction

    // expected neighbor list for one accepted transaction
    function automatic void predict_neighbors(input point_op_t op);
        longint      cand_d [MAX_POINTS];
        logic [5:0]  cand_i [MAX_POINTS];
        longint      dx;
        longint      dy;
        longint      d;
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned total;
        nbr_result_t res;
        case (op.func)
            FUNC_CLEAR: stored_count = 0;
            FUNC_ADD:
            begin
                if (stored_count < MAX_POINTS)
                begin
                    pt_x[stored_count] = op.x;
                    pt_y[stored_count] = op.y;
                    stored_count++;
                end
            end
            FUNC_QUERY:
            begin
                if (op.idx >= stored_count)
                    expect_result(BAD_IDX);
                else
                begin
                    // stable insertion keeps the lower index first on equal distance
                    n = 0;
                    for (j = 0; j < stored_count; j++)
                    begin
                        if (j != op.idx)
                        begin
                            dx = longint'(pt_x[op.idx]) - longint'(pt_x[j]);
                            dy = longint'(pt_y[op.idx]) - longint'(pt_y[j]);
                            d = dx * dx + dy * dy;
                            i = n;
                            while (i > 0 && cand_d[i-1] > d)
                            begin
                                cand_d[i] = cand_d[i-1];
                                cand_i[i] = cand_i[i-1];
                                i--;
                            end
                            cand_d[i] = d;
                            cand_i[i] = 6'(j);
                            n++;
                        end
                    end
                    total = (neighbor_k < stored_count - 1) ? neighbor_k : stored_count - 1;
                    for (i = 0; i < total; i++)
                    begin
                        res.status = ST_OK;
                        res.rank   = 6'(i);
                        res.nbr    = cand_i[i];
                        res.dsq    = DIST_W'(cand_d[i]);
                        res.last   = (i + 1 == total);
                        expect_result(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // offer one transaction and hold it until accepted
    task automatic send_op(input point_op_t op, input int gap, input bit typed,
                           input nbr_result_t want);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op.func;
        x_coord     <= op.x;
        y_coord     <= op.y;
        point_index <= op.idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed)
            expect_result(want);
        else
            predict_neighbors(op);
        if (op.func != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic send_plain(input logic [1:0] f, input logic [15:0] x, input logic [15:0] y,
                              input logic [5:0] idx, input int gap);
        point_op_t op;
        op.func = f;
        op.x    = x;
        op.y    = y;
        op.idx  = idx;
        send_op(op, gap, 1'b0, NO_RESULT);
    endtask

    // wait for every pending result, then let a silent query finish
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_neighbor_count(input logic [5:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        neighbor_k  = value;
    endtask

    function automatic int send_gap();
        return steady ? 0 : pick_gap();
    endfunction

    // one random batch: mostly a fresh point set with queries, else noise
    task automatic run_point_batch();
        int mode;
        int n_pts;
        int n_q;
        int i;
        int hi;
        logic [1:0] f;
        if ($urandom_range(0, 99) < 80)
        begin
            mode  = $urandom_range(0, 3);
            n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 12);
            // now and then keep the old store so points accumulate
            if ($urandom_range(0, 5) != 0)
                send_plain(FUNC_CLEAR, 16'($urandom), 16'($urandom), 6'($urandom), send_gap());
            for (i = 0; i < n_pts; i++)
                send_plain(FUNC_ADD, rand_coord(mode), rand_coord(mode), 6'($urandom),
                           send_gap());
            n_q = $urandom_range(1, 4);
            hi  = (n_pts > MAX_POINTS) ? MAX_POINTS - 1 : n_pts - 1;
            for (i = 0; i < n_q; i++)
                send_plain(FUNC_QUERY, 16'($urandom), 16'($urandom),
                           ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, hi)),
                           send_gap());
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                f = 2'($urandom_range(0, 3));
                send_plain(f, rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                           6'($urandom), send_gap());
            end
        end
    endtask

    // receiver: random stalls, steady stretches, one long hold-off on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = steady ? 0 : pick_gap();
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        nbr_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_neighbors.size() == 0)
                report_mismatch("result with nothing pending, neighbor_index",
                                neighbor_index, 0);
            else
            begin
                want = pending_neighbors.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (rank !== want.rank)
                    report_mismatch("rank", rank, want.rank);
                if (neighbor_index !== want.nbr)
                    report_mismatch("neighbor_index", neighbor_index, want.nbr);
                if (distance_squared !== want.dsq)
                    report_mismatch("distance_squared", distance_squared, want.dsq);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    // main sequence
    initial
    begin
        int row;
        int i;
        int phase;
        int start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table at the reset neighbor count
        for (row = 0; row < DIR_ROWS; row++)
            send_op(dir_table[row].op, pick_gap(), dir_table[row].typed, dir_table[row].want);

        // full store at the largest neighbor count, adds past capacity are dropped
        settle_block();
        write_neighbor_count(6'd63);
        send_plain(FUNC_CLEAR, 16'h0, 16'h0, 6'd0, 0);
        for (i = 0; i < MAX_POINTS + 2; i++)
            send_plain(FUNC_ADD, rand_coord(i % 4), rand_coord((i + 1) % 4), 6'($urandom),
                       pick_gap());
        send_plain(FUNC_QUERY, 16'h0, 16'h0, 6'd0, pick_gap());
        send_plain(FUNC_QUERY, 16'h0, 16'h0, 6'd63, pick_gap());
        send_plain(FUNC_QUERY, 16'h0, 16'h0, 6'($urandom), pick_gap());

        // zero neighbor count: only bad indexes give a result
        settle_block();
        write_neighbor_count(6'd0);
        send_plain(FUNC_CLEAR, 16'h0, 16'h0, 6'd0, 0);
        for (i = 0; i < 6; i++)
            send_plain(FUNC_ADD, rand_coord(3), rand_coord(3), 6'd0, pick_gap());
        send_plain(FUNC_QUERY, 16'h0, 16'h0, 6'd2, pick_gap());
        send_plain(FUNC_QUERY, 16'h0, 16'h0, 6'd7, pick_gap());

        // back-pressure: receiver holds off while queries keep coming
        settle_block();
        write_neighbor_count(6'd8);
        send_plain(FUNC_CLEAR, 16'h0, 16'h0, 6'd0, 0);
        for (i = 0; i < 20; i++)
            send_plain(FUNC_ADD, rand_coord(0), rand_coord(3), 6'd0, 0);
        hold_request = 1'b1;
        for (i = 0; i < 10; i++)
            send_plain(FUNC_QUERY, 16'h0, 16'h0, 6'($urandom_range(0, 19)), 0);

        // random phases with varying neighbor count
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            settle_block();
            case (phase % 5)
                0: write_neighbor_count(6'd1);
                1: write_neighbor_count(6'($urandom_range(2, 10)));
                2: write_neighbor_count(6'd63);
                3: write_neighbor_count(6'($urandom_range(11, 62)));
                default: write_neighbor_count(6'd0);
            endcase
            steady = (phase % 3 == 2);
            start  = items_sent;
            while (items_sent - start < 60 && items_sent < TOTAL_ITEMS)
                run_point_batch();
            phase++;
        end

        settle_block();
        if (error_count == 0)
            $display("** k_nearest_points_2d: PASSED **");
        else
            $display("** k_nearest_points_2d: FAILED **");
        $finish;
    end

endmodule
